[rtl/apr_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants of the affine point and rectangle mapper.
// -----------------------------------------------------------------------------
package apr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COEF_W    = 32;
	localparam int POS_W     = 16;
	localparam int EXT_W     = 15;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_XY_W  = 32;
	localparam int OUT_WH_W  = 31;

	// Product of a Q16.16 coefficient and a 16 bit operand.
	localparam int PROD_W  = COEF_W + POS_W;
	// Sum of two products and an offset.
	localparam int BASE_W  = PROD_W + 2;
	// Sum of two corner deltas of one sign.
	localparam int DELTA_W = PROD_W + 1;
	// Extreme corner coordinate in Q35.16.
	localparam int ACC_W   = BASE_W + 1;
	// Integer part of a corner coordinate.
	localparam int COORD_W = ACC_W - FRAC_BITS;
	// Difference of two integer coordinates.
	localparam int SPAN_W  = COORD_W + 1;

	localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(32'sh0001_0000);
	localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A   = 3'd0,
		REG_COEF_B   = 3'd1,
		REG_COEF_C   = 3'd2,
		REG_COEF_D   = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
		logic signed [COEF_W-1:0] coef_d;
		logic signed [COEF_W-1:0] offset_x;
		logic signed [COEF_W-1:0] offset_y;
	} coef_t;

	typedef struct packed {
		logic                    kind;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [EXT_W-1:0]        extent_w;
		logic [EXT_W-1:0]        extent_h;
	} item_t;

	// Products of the multiplier stage.
	typedef struct packed {
		logic                     rect;
		logic signed [PROD_W-1:0] ax;
		logic signed [PROD_W-1:0] by;
		logic signed [PROD_W-1:0] cx;
		logic signed [PROD_W-1:0] dy;
		logic signed [PROD_W-1:0] aw;
		logic signed [PROD_W-1:0] bh;
		logic signed [PROD_W-1:0] cw;
		logic signed [PROD_W-1:0] dh;
	} prod_t;

	// Extreme corners on each axis in Q35.16.
	typedef struct packed {
		logic                    rect;
		logic signed [ACC_W-1:0] lo_x;
		logic signed [ACC_W-1:0] hi_x;
		logic signed [ACC_W-1:0] lo_y;
		logic signed [ACC_W-1:0] hi_y;
	} corner_t;

	typedef struct packed {
		logic signed [OUT_XY_W-1:0] out_x;
		logic signed [OUT_XY_W-1:0] out_y;
		logic [OUT_WH_W-1:0]        out_w;
		logic [OUT_WH_W-1:0]        out_h;
	} result_t;

endpackage
`default_nettype wire

[rtl/apr_if.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// apr_if
// Valid/ready channels of the mapper: input items, results and register writes.
// -----------------------------------------------------------------------------
interface apr_item_if
	import apr_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [EXT_W-1:0]        extent_w;
	logic [EXT_W-1:0]        extent_h;

	modport source (output valid, kind, pos_x, pos_y, extent_w, extent_h, input ready);
	modport sink (input valid, kind, pos_x, pos_y, extent_w, extent_h, output ready);
endinterface

interface apr_result_if
	import apr_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_XY_W-1:0] out_x;
	logic signed [OUT_XY_W-1:0] out_y;
	logic [OUT_WH_W-1:0]        out_w;
	logic [OUT_WH_W-1:0]        out_h;

	modport source (output valid, out_x, out_y, out_w, out_h, input ready);
	modport sink (input valid, out_x, out_y, out_w, out_h, output ready);
endinterface

interface apr_cfg_if
	import apr_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/apr_cfg_regs.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// apr_cfg_regs
// Matrix and translation registers, written through the configuration channel.
// -----------------------------------------------------------------------------
module apr_cfg_regs
	import apr_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	apr_cfg_if.sink     cfg,
	output coef_t       coef
);

	coef_t coef_q;

	assign cfg.ready = 1'b1;
	assign coef      = coef_q;

	// Writes to an index beyond the offset registers are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.coef_a   <= COEF_ONE;
			coef_q.coef_b   <= COEF_ZERO;
			coef_q.coef_c   <= COEF_ZERO;
			coef_q.coef_d   <= COEF_ONE;
			coef_q.offset_x <= COEF_ZERO;
			coef_q.offset_y <= COEF_ZERO;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COEF_A:   coef_q.coef_a   <= $signed(cfg.data);
				REG_COEF_B:   coef_q.coef_b   <= $signed(cfg.data);
				REG_COEF_C:   coef_q.coef_c   <= $signed(cfg.data);
				REG_COEF_D:   coef_q.coef_d   <= $signed(cfg.data);
				REG_OFFSET_X: coef_q.offset_x <= $signed(cfg.data);
				REG_OFFSET_Y: coef_q.offset_y <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/apr_mul_stage.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// apr_mul_stage
// First pipeline stage: the eight coefficient products of an item.
// -----------------------------------------------------------------------------
module apr_mul_stage
	import apr_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  coef_t coef,
	input  wire   in_valid,
	output logic  in_ready,
	input  item_t in_data,
	output logic  out_valid,
	input  wire   out_ready,
	output prod_t out_data
);

	logic                    valid_s1;
	prod_t                   prod_s1;
	prod_t                   prod_d;
	logic signed [POS_W-1:0] w_op;
	logic signed [POS_W-1:0] h_op;

	// A point has no extent, so its corner deltas come out as zero.
	always_comb begin
		w_op          = in_data.kind ? $signed({1'b0, in_data.extent_w}) : '0;
		h_op          = in_data.kind ? $signed({1'b0, in_data.extent_h}) : '0;
		prod_d.rect   = in_data.kind;
		prod_d.ax     = coef.coef_a * in_data.pos_x;
		prod_d.by     = coef.coef_b * in_data.pos_y;
		prod_d.cx     = coef.coef_c * in_data.pos_x;
		prod_d.dy     = coef.coef_d * in_data.pos_y;
		prod_d.aw     = coef.coef_a * w_op;
		prod_d.bh     = coef.coef_b * h_op;
		prod_d.cw     = coef.coef_c * w_op;
		prod_d.dh     = coef.coef_d * h_op;
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_s1 <= prod_d;
		end
	end

endmodule
`default_nettype wire

[rtl/apr_sum_stage.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// apr_sum_stage
// Second and third pipeline stages: mapped origin corner and corner deltas,
// then the minimum and maximum corner on each axis.
// -----------------------------------------------------------------------------
module apr_sum_stage
	import apr_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  coef_t   coef,
	input  wire     in_valid,
	output logic    in_ready,
	input  prod_t   in_data,
	output logic    out_valid,
	input  wire     out_ready,
	output corner_t out_data
);

	typedef struct packed {
		logic                      rect;
		logic signed [BASE_W-1:0]  base_x;
		logic signed [BASE_W-1:0]  base_y;
		logic signed [DELTA_W-1:0] dlo_x;
		logic signed [DELTA_W-1:0] dhi_x;
		logic signed [DELTA_W-1:0] dlo_y;
		logic signed [DELTA_W-1:0] dhi_y;
	} base_t;

	logic    valid_s2;
	logic    valid_s3;
	logic    ready_s2;
	base_t   base_s2;
	base_t   base_d;
	corner_t corner_s3;
	corner_t corner_d;

	function automatic logic signed [DELTA_W-1:0] neg_part(input logic signed [PROD_W-1:0] v);
		neg_part = v[PROD_W-1] ? DELTA_W'(v) : '0;
	endfunction

	function automatic logic signed [DELTA_W-1:0] pos_part(input logic signed [PROD_W-1:0] v);
		pos_part = v[PROD_W-1] ? '0 : DELTA_W'(v);
	endfunction

	// The corners differ from the origin corner by a*w, b*h or both (c*w, d*h on y), so the
	// extremes are the origin plus the negative or positive parts of those terms.
	always_comb begin
		base_d.rect   = in_data.rect;
		base_d.base_x = BASE_W'(in_data.ax) + BASE_W'(in_data.by) + BASE_W'(coef.offset_x);
		base_d.base_y = BASE_W'(in_data.cx) + BASE_W'(in_data.dy) + BASE_W'(coef.offset_y);
		base_d.dlo_x  = neg_part(in_data.aw) + neg_part(in_data.bh);
		base_d.dhi_x  = pos_part(in_data.aw) + pos_part(in_data.bh);
		base_d.dlo_y  = neg_part(in_data.cw) + neg_part(in_data.dh);
		base_d.dhi_y  = pos_part(in_data.cw) + pos_part(in_data.dh);
	end

	always_comb begin
		corner_d.rect = base_s2.rect;
		corner_d.lo_x = ACC_W'(base_s2.base_x) + ACC_W'(base_s2.dlo_x);
		corner_d.hi_x = ACC_W'(base_s2.base_x) + ACC_W'(base_s2.dhi_x);
		corner_d.lo_y = ACC_W'(base_s2.base_y) + ACC_W'(base_s2.dlo_y);
		corner_d.hi_y = ACC_W'(base_s2.base_y) + ACC_W'(base_s2.dhi_y);
	end

	assign ready_s2  = !valid_s3 || out_ready;
	assign in_ready  = !valid_s2 || ready_s2;
	assign out_valid = valid_s3;
	assign out_data  = corner_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (ready_s2) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			base_s2 <= base_d;
		end
		if (ready_s2 && valid_s2) begin
			corner_s3 <= corner_d;
		end
	end

endmodule
`default_nettype wire

[rtl/apr_fix_stage.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// apr_fix_stage
// Fourth and fifth pipeline stages: rounding, floor and ceiling to integers,
// then box size and saturation into the result register.
// -----------------------------------------------------------------------------
module apr_fix_stage
	import apr_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     in_valid,
	output logic    in_ready,
	input  corner_t in_data,
	output logic    out_valid,
	input  wire     out_ready,
	output result_t out_data
);

	typedef struct packed {
		logic                      rect;
		logic signed [COORD_W-1:0] left_x;
		logic signed [COORD_W-1:0] right_x;
		logic signed [COORD_W-1:0] left_y;
		logic signed [COORD_W-1:0] right_y;
	} int_t;

	localparam logic signed [ACC_W-1:0] HALF_UP  = ACC_W'(1 << (FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] HALF_DN  = ACC_W'((1 << (FRAC_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] CEIL_ADD = ACC_W'((1 << FRAC_BITS) - 1);

	logic                    valid_s4;
	logic                    valid_s5;
	logic                    ready_s4;
	int_t                    int_s4;
	int_t                    int_d;
	result_t                 res_s5;
	result_t                 res_d;
	logic                    rect_s5;
	logic signed [ACC_W-1:0] fl_x;
	logic signed [ACC_W-1:0] fl_y;
	logic signed [ACC_W-1:0] cl_x;
	logic signed [ACC_W-1:0] cl_y;
	logic signed [SPAN_W-1:0] span_x;
	logic signed [SPAN_W-1:0] span_y;

	function automatic logic signed [OUT_XY_W-1:0] sat_xy(input logic signed [COORD_W-1:0] v);
		logic all_one;
		logic all_zero;
		all_one  = &v[COORD_W-1:OUT_XY_W-1];
		all_zero = ~|v[COORD_W-1:OUT_XY_W-1];
		if (all_one || all_zero) begin
			sat_xy = v[OUT_XY_W-1:0];
		end else if (v[COORD_W-1]) begin
			sat_xy = {1'b1, {(OUT_XY_W-1){1'b0}}};
		end else begin
			sat_xy = {1'b0, {(OUT_XY_W-1){1'b1}}};
		end
	endfunction

	function automatic logic [OUT_WH_W-1:0] sat_wh(input logic signed [SPAN_W-1:0] v);
		if (v[SPAN_W-1]) begin
			sat_wh = '0;
		end else if (|v[SPAN_W-2:OUT_WH_W]) begin
			sat_wh = '1;
		end else begin
			sat_wh = v[OUT_WH_W-1:0];
		end
	endfunction

	// A point rounds half away from zero: a negative value gets a bias one
	// short of a half before the arithmetic shift. A rectangle takes the floor
	// of its minimum and the ceiling of its maximum.
	always_comb begin
		if (in_data.rect) begin
			fl_x = in_data.lo_x;
			fl_y = in_data.lo_y;
		end else begin
			fl_x = in_data.lo_x + (in_data.lo_x[ACC_W-1] ? HALF_DN : HALF_UP);
			fl_y = in_data.lo_y + (in_data.lo_y[ACC_W-1] ? HALF_DN : HALF_UP);
		end
		cl_x          = in_data.hi_x + CEIL_ADD;
		cl_y          = in_data.hi_y + CEIL_ADD;
		int_d.rect    = in_data.rect;
		int_d.left_x  = fl_x[ACC_W-1:FRAC_BITS];
		int_d.left_y  = fl_y[ACC_W-1:FRAC_BITS];
		int_d.right_x = cl_x[ACC_W-1:FRAC_BITS];
		int_d.right_y = cl_y[ACC_W-1:FRAC_BITS];
	end

	always_comb begin
		span_x      = SPAN_W'(int_s4.right_x) - SPAN_W'(int_s4.left_x);
		span_y      = SPAN_W'(int_s4.right_y) - SPAN_W'(int_s4.left_y);
		res_d.out_x = sat_xy(int_s4.left_x);
		res_d.out_y = sat_xy(int_s4.left_y);
		res_d.out_w = int_s4.rect ? sat_wh(span_x) : '0;
		res_d.out_h = int_s4.rect ? sat_wh(span_y) : '0;
	end

	assign ready_s4  = !valid_s5 || out_ready;
	assign in_ready  = !valid_s4 || ready_s4;
	assign out_valid = valid_s5;
	assign out_data  = res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s4 <= in_valid;
			end
			if (ready_s4) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			int_s4 <= int_d;
		end
		if (ready_s4 && valid_s4) begin
			res_s5  <= res_d;
			rect_s5 <= int_s4.rect;
		end
	end

	// The maximum corner never lies below the minimum one.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && int_s4.rect |-> (int_s4.right_x >= int_s4.left_x) &&
			(int_s4.right_y >= int_s4.left_y))
		else $error("apr_fix_stage: box edge order inverted");

	// A point result carries no box size.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !rect_s5 |-> (res_s5.out_w == '0) && (res_s5.out_h == '0))
		else $error("apr_fix_stage: point result with non-zero size");

	// A stalled item in the rounding stage stays put until it moves on.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !ready_s4 |=> valid_s4 && $stable(int_s4))
		else $error("apr_fix_stage: stalled stage lost or changed its item");

endmodule
`default_nettype wire

[rtl/affine_point_rect_mapper.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// affine_point_rect_mapper
// Maps points, or the bounding box of rectangles, through a Q16.16 affine
// matrix held in six registers.
// -----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  item     in         kind, pos_x, pos_y, extent_w, extent_h
//  result   out        out_x, out_y, out_w, out_h
//  cfg      in         index, data (register write, always ready)
//
// Five register stages: products, origin and deltas, extremes, integer
// conversion, saturation into the result register. One item per cycle
// while the result side does not stall; an item passes these stages in order,
// and its result, once valid, can be transferred at the following edge.
// Reset clears every stage's valid bit and restores the identity matrix.
// The ready chain is combinational, so a stall on the result side holds the
// full stages at the result end in the same cycle; those behind a bubble move.
// -----------------------------------------------------------------------------
module affine_point_rect_mapper
	import apr_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	apr_item_if.sink     item,
	apr_result_if.source result,
	apr_cfg_if.sink      cfg
);

	coef_t   coef;
	item_t   item_data;
	logic    prod_valid;
	logic    prod_ready;
	prod_t   prod_data;
	logic    corner_valid;
	logic    corner_ready;
	corner_t corner_data;
	result_t res_data;

	assign item_data.kind     = item.kind;
	assign item_data.pos_x    = item.pos_x;
	assign item_data.pos_y    = item.pos_y;
	assign item_data.extent_w = item.extent_w;
	assign item_data.extent_h = item.extent_h;

	apr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef)
	);

	apr_mul_stage u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_data   (item_data),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_data  (prod_data)
	);

	apr_sum_stage u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (prod_valid),
		.in_ready  (prod_ready),
		.in_data   (prod_data),
		.out_valid (corner_valid),
		.out_ready (corner_ready),
		.out_data  (corner_data)
	);

	apr_fix_stage u_fix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (corner_valid),
		.in_ready  (corner_ready),
		.in_data   (corner_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res_data)
	);

	assign result.out_x = res_data.out_x;
	assign result.out_y = res_data.out_y;
	assign result.out_w = res_data.out_w;
	assign result.out_h = res_data.out_h;

endmodule
`default_nettype wire
